[rtl/alist_pkg.sv]
`default_nettype none

package alist_pkg;

  localparam int DEPTH = 1024;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int IW    = 11;
  localparam int LW    = 11;
  localparam int VW    = 32;
  localparam int CMPW  = (CW > IW) ? CW : IW;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_READ    = 2'd1,
    OP_DEL_IDX = 2'd2,
    OP_DEL_VAL = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_INDEX = 3'd1,
    ST_FULL      = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  typedef struct packed {
    op_t                  op;
    logic [IW-1:0]        index;
    logic signed [VW-1:0] value;
  } req_t;

  typedef struct packed {
    status_t              status;
    logic signed [VW-1:0] read_value;
    logic [LW-1:0]        list_length;
  } rsp_t;

endpackage

`default_nettype wire

[rtl/alist_ram.sv]
`default_nettype none

module alist_ram (
  input  wire                              clk,
  input  wire                              we,
  input  wire  [alist_pkg::AW-1:0]         waddr,
  input  wire  signed [alist_pkg::VW-1:0]  wdata,
  input  wire  [alist_pkg::AW-1:0]         raddr,
  output logic signed [alist_pkg::VW-1:0]  rdata
);
  import alist_pkg::*;

  logic signed [VW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/array_list_insert_delete.sv]
`default_nettype none

// Channel | Direction | Handshake                  | Payload
// req     | in        | req_valid / req_ready      | alist_pkg::req_t (op, index, value)
// rsp     | out       | rsp_valid / rsp_ready      | alist_pkg::rsp_t (status, read_value, list_length)
//
// One request is handled at a time. A read passes through S_READ to the response, and an
// error goes straight to it. Insert shifts the entries from index up in S_SHIFT and then
// writes the new entry in S_INS, or writes at once at the end of the list. Delete at index
// shifts the later entries down, or only lowers the count for the last entry, and delete by
// value searches in S_SEARCH and then deletes as at index: the list RAM moves or compares
// one entry per cycle through its single read port and single write port. Reset clears the
// count and the control state; the RAM contents are not cleared. A stalled response holds its
// register, and the next response waits for it, while a new request is taken once the block is idle.

module array_list_insert_delete (
  input  wire              clk,
  input  wire              rst,
  input  wire              req_valid,
  output logic             req_ready,
  input  alist_pkg::req_t  req,
  output logic             rsp_valid,
  input  wire              rsp_ready,
  output alist_pkg::rsp_t  rsp
);
  import alist_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SEARCH,
    S_SHIFT,
    S_INS,
    S_RESP
  } state_t;

  state_t               state;
  logic [CW-1:0]        cnt;
  logic [AW-1:0]        pos;
  logic signed [VW-1:0] val;
  logic [AW-1:0]        rk;
  logic [AW-1:0]        rk_d;
  logic [AW-1:0]        rk_end;
  logic                 issue;
  logic                 pend;
  logic                 up;
  status_t              res_status;
  logic signed [VW-1:0] res_rd;

  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic signed [VW-1:0] mem_wdata;
  logic [AW-1:0]        mem_raddr;
  logic signed [VW-1:0] mem_rdata;

  logic [CMPW-1:0]      idx_w;
  logic [CMPW-1:0]      cnt_w;
  logic [AW-1:0]        idx_addr;
  logic [CW-1:0]        cnt_m1;
  logic [AW-1:0]        cnt_last;

  assign idx_w     = CMPW'(req.index);
  assign cnt_w     = CMPW'(cnt);
  assign idx_addr  = idx_w[AW-1:0];
  assign cnt_m1    = cnt - 1'b1;
  assign cnt_last  = cnt_m1[AW-1:0];
  assign req_ready = (state == S_IDLE);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = rk_d;
    mem_wdata = mem_rdata;
    mem_raddr = rk;
    case (state)
      S_IDLE: begin
        mem_raddr = idx_addr;
      end
      S_SHIFT: begin
        mem_we    = pend;
        mem_waddr = up ? rk_d + 1'b1 : rk_d - 1'b1;
      end
      S_INS: begin
        mem_we    = 1'b1;
        mem_waddr = pos;
        mem_wdata = val;
      end
      default: begin
      end
    endcase
  end

  alist_ram u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      rsp_valid <= 1'b0;
      issue     <= 1'b0;
      pend      <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            val        <= req.value;
            pos        <= idx_addr;
            res_rd     <= '0;
            res_status <= ST_OK;
            pend       <= 1'b0;
            state      <= S_RESP;
            case (req.op)
              OP_INSERT: begin
                if (idx_w > cnt_w) begin
                  res_status <= ST_BAD_INDEX;
                end else if (cnt == CW'(DEPTH)) begin
                  res_status <= ST_FULL;
                end else if (idx_w == cnt_w) begin
                  state <= S_INS;
                end else begin
                  rk     <= cnt_last;
                  rk_end <= idx_addr;
                  up     <= 1'b1;
                  issue  <= 1'b1;
                  state  <= S_SHIFT;
                end
              end
              OP_READ: begin
                if (idx_w >= cnt_w) begin
                  res_status <= ST_BAD_INDEX;
                end else begin
                  state <= S_READ;
                end
              end
              OP_DEL_IDX: begin
                if (cnt == '0) begin
                  res_status <= ST_EMPTY;
                end else if (idx_w >= cnt_w) begin
                  res_status <= ST_BAD_INDEX;
                end else if (idx_addr == cnt_last) begin
                  cnt <= cnt_m1;
                end else begin
                  rk     <= idx_addr + 1'b1;
                  rk_end <= cnt_last;
                  up     <= 1'b0;
                  issue  <= 1'b1;
                  state  <= S_SHIFT;
                end
              end
              default: begin
                if (cnt == '0) begin
                  res_status <= ST_EMPTY;
                end else begin
                  rk    <= '0;
                  issue <= 1'b1;
                  state <= S_SEARCH;
                end
              end
            endcase
          end
        end
        S_READ: begin
          res_rd <= mem_rdata;
          state  <= S_RESP;
        end
        S_SEARCH: begin
          pend <= issue;
          rk_d <= rk;
          if (issue) begin
            if (rk == cnt_last) begin
              issue <= 1'b0;
            end else begin
              rk <= rk + 1'b1;
            end
          end
          if (pend) begin
            if (mem_rdata == val) begin
              issue <= 1'b0;
              pend  <= 1'b0;
              if (rk_d == cnt_last) begin
                cnt   <= cnt_m1;
                state <= S_RESP;
              end else begin
                rk     <= rk_d + 1'b1;
                rk_end <= cnt_last;
                up     <= 1'b0;
                issue  <= 1'b1;
                state  <= S_SHIFT;
              end
            end else if (rk_d == cnt_last) begin
              res_status <= ST_NOT_FOUND;
              state      <= S_RESP;
            end
          end
        end
        S_SHIFT: begin
          pend <= issue;
          rk_d <= rk;
          if (issue) begin
            if (rk == rk_end) begin
              issue <= 1'b0;
            end else begin
              rk <= up ? rk - 1'b1 : rk + 1'b1;
            end
          end else if (pend) begin
            if (up) begin
              state <= S_INS;
            end else begin
              cnt   <= cnt_m1;
              state <= S_RESP;
            end
          end
        end
        S_INS: begin
          cnt   <= cnt + 1'b1;
          state <= S_RESP;
        end
        S_RESP: begin
          if (!rsp_valid || rsp_ready) begin
            rsp.status      <= res_status;
            rsp.read_value  <= res_rd;
            rsp.list_length <= LW'(cnt);
            rsp_valid       <= 1'b1;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(DEPTH))
    else $error("list count exceeds the capacity");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request taken while another is in progress");

  a_write_states: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_SHIFT || state == S_INS))
    else $error("list RAM written outside a shift or insert");

  a_rsp_from_resp: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == S_RESP))
    else $error("response raised without a finished request");

endmodule

`default_nettype wire

[bench/array_list_insert_delete_test.sv]
`timescale 1ns / 100ps

module array_list_insert_delete_test;
  import alist_pkg::*;

  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AT = 150;

  typedef struct packed {
    req_t req;
    int   gap;
    bit   drain;
  } pending_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  array_list_insert_delete uut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic signed [VW-1:0] list_mem [DEPTH];
  logic [CW-1:0]        list_count = '0;
  int                   peak_len = 0;
  rsp_t                 expected_rsp_q [$];

  pending_t             pending_q [$];
  logic signed [VW-1:0] plan_vals [$];
  longint               budget = 0;
  longint               cycle_limit = 64'd100000000;
  longint               cycles = 0;

  int errors = 0;
  int accepted = 0;
  int received = 0;
  int op_seen [4] = '{0, 0, 0, 0};
  int status_seen [5] = '{0, 0, 0, 0, 0};

  function automatic void drop_entry(int pos);
    int k;
    for (k = pos; k + 1 < list_count; k++) list_mem[k] = list_mem[k + 1];
    list_count = list_count - 1'b1;
  endfunction

  function automatic rsp_t apply_list_op(req_t r);
    rsp_t res;
    int   k;
    res.status = ST_OK;
    res.read_value = '0;
    case (r.op)
      OP_INSERT: begin
        if (r.index > list_count) begin
          res.status = ST_BAD_INDEX;
        end else if (list_count >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          for (k = list_count; k > r.index; k--) list_mem[k] = list_mem[k - 1];
          list_mem[r.index] = r.value;
          list_count = list_count + 1'b1;
        end
      end
      OP_READ: begin
        if (r.index >= list_count) res.status = ST_BAD_INDEX;
        else res.read_value = list_mem[r.index];
      end
      OP_DEL_IDX: begin
        if (list_count == 0) res.status = ST_EMPTY;
        else if (r.index >= list_count) res.status = ST_BAD_INDEX;
        else drop_entry(r.index);
      end
      default: begin
        if (list_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          k = 0;
          while (k < list_count && list_mem[k] != r.value) k++;
          if (k < list_count) drop_entry(k);
          else res.status = ST_NOT_FOUND;
        end
      end
    endcase
    res.list_length = list_count;
    if (list_count > peak_len) peak_len = list_count;
    return res;
  endfunction

  function automatic void plan_item(op_t op, int index, logic signed [VW-1:0] value, int gap,
                                    bit drain);
    pending_t p;
    int       n;
    int       k;
    n = plan_vals.size();
    budget += 2 * n + 20 + gap;
    p.req.op = op;
    p.req.index = index[IW-1:0];
    p.req.value = value;
    p.gap = gap;
    p.drain = drain;
    pending_q.push_back(p);
    case (op)
      OP_INSERT: if (index <= n && n < DEPTH) plan_vals.insert(index, value);
      OP_DEL_IDX: if (index < n) plan_vals.delete(index);
      OP_DEL_VAL: begin
        k = 0;
        while (k < n && plan_vals[k] != value) k++;
        if (k < n) plan_vals.delete(k);
      end
      default: ;
    endcase
  endfunction

  function automatic int draw_gap(int seq);
    if (seq % 100 < 20) return 0;
    return $urandom_range(3, 0);
  endfunction

  function automatic logic signed [VW-1:0] pick_value();
    if ($urandom_range(1, 0) == 0) return $urandom;
    case ($urandom_range(7, 0))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      4: return 32'h0000_0001;
      5: return 32'h5555_5555;
      6: return 32'haaaa_aaaa;
      default: return 32'd17;
    endcase
  endfunction

  always @(posedge clk) begin : drive_proc
    pending_t nxt;
    logic     offer;
    int       send_wait;
    if (rst) begin
      req_valid <= 1'b0;
      send_wait = 0;
    end else begin
      offer = req_valid;
      if (req_valid && req_ready) begin
        expected_rsp_q.push_back(apply_list_op(req));
        op_seen[int'(req.op)]++;
        accepted++;
        offer = 1'b0;
      end
      if (!offer) begin
        if (send_wait > 0) begin
          send_wait--;
        end else if (pending_q.size() != 0 &&
                     !(pending_q[0].drain && expected_rsp_q.size() != 0)) begin
          nxt = pending_q.pop_front();
          req <= nxt.req;
          send_wait = nxt.gap;
          offer = 1'b1;
        end
      end
      req_valid <= offer;
    end
  end

  always @(posedge clk) begin : check_proc
    rsp_t want;
    int   recv_wait;
    int   hold_left;
    if (rst) begin
      rsp_ready <= 1'b0;
      recv_wait = 0;
      hold_left = 0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        // A transfer that finds no expectation waiting is an error.
        if (expected_rsp_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected response status %0d read_value %0d list_length %0d",
                   $time, rsp.status, rsp.read_value, rsp.list_length);
        end else begin
          want = expected_rsp_q.pop_front();
          status_seen[int'(want.status)]++;
          if (rsp.status !== want.status) begin
            errors++;
            $display("%0t: status expected %0d actual %0d", $time, want.status, rsp.status);
          end
          if (rsp.read_value !== want.read_value) begin
            errors++;
            $display("%0t: read_value expected %0d actual %0d", $time, want.read_value,
                     rsp.read_value);
          end
          if (rsp.list_length !== want.list_length) begin
            errors++;
            $display("%0t: list_length expected %0d actual %0d", $time, want.list_length,
                     rsp.list_length);
          end
        end
        received++;
        if (received == HOLD_AT) hold_left = HOLD_CYCLES;
        recv_wait = (received % 128 < 30) ? 0 : $urandom_range(3, 0);
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ready <= 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait--;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : watchdog_proc
    cycles <= cycles + 1;
    if (cycles > cycle_limit) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("array_list_insert_delete test failed");
      $finish;
    end
  end

  initial begin : main_proc
    int   i;
    int   n;
    int   r;
    int   w;
    int   idx;
    int   target;
    bit   grow;
    op_t  op;
    logic signed [VW-1:0] v;

    plan_item(OP_READ, 0, 32'd0, draw_gap(1), 1'b0);
    plan_item(OP_DEL_IDX, 0, 32'd0, draw_gap(1), 1'b0);
    plan_item(OP_DEL_VAL, 0, 32'd5, draw_gap(1), 1'b0);
    plan_item(OP_INSERT, 1, 32'd9, draw_gap(1), 1'b0);
    plan_item(OP_INSERT, 2047, 32'hffff_ffff, draw_gap(1), 1'b0);
    plan_item(OP_INSERT, 0, 32'h8000_0000, draw_gap(1), 1'b0);
    plan_item(OP_INSERT, 1, 32'h7fff_ffff, draw_gap(1), 1'b0);
    plan_item(OP_INSERT, 1, 32'hffff_ffff, draw_gap(1), 1'b0);
    plan_item(OP_INSERT, 0, 32'h0000_0000, draw_gap(1), 1'b0);
    plan_item(OP_INSERT, 4, 32'h7fff_ffff, draw_gap(1), 1'b0);
    for (i = 0; i < 5; i++) plan_item(OP_READ, i, 32'hffff_ffff, draw_gap(1), 1'b0);
    plan_item(OP_READ, 5, 32'd0, draw_gap(1), 1'b0);
    plan_item(OP_READ, 2047, 32'd0, draw_gap(1), 1'b0);
    plan_item(OP_DEL_VAL, 2047, 32'd12345, draw_gap(1), 1'b0);
    plan_item(OP_DEL_VAL, 0, 32'h7fff_ffff, draw_gap(1), 1'b0);
    plan_item(OP_READ, 3, 32'd0, draw_gap(1), 1'b0);
    plan_item(OP_DEL_IDX, 4, 32'd0, draw_gap(1), 1'b0);
    plan_item(OP_DEL_IDX, 1, 32'd0, draw_gap(1), 1'b0);
    plan_item(OP_DEL_IDX, 2, 32'd0, draw_gap(1), 1'b0);
    plan_item(OP_DEL_VAL, 0, 32'hffff_ffff, draw_gap(1), 1'b0);
    plan_item(OP_DEL_IDX, 0, 32'd0, draw_gap(1), 1'b0);

    target = 0;
    for (i = 0; i < 580; i++) begin
      if (i % 60 == 0) begin
        case ($urandom_range(4, 0))
          0: target = 0;
          1: target = 2;
          2: target = 8;
          3: target = 24;
          default: target = 60;
        endcase
      end
      n = plan_vals.size();
      grow = (n < target);
      r = $urandom_range(99, 0);
      if (r < (grow ? 55 : 25)) op = OP_INSERT;
      else if (r < (grow ? 70 : 45)) op = OP_READ;
      else if (r < (grow ? 85 : 72)) op = OP_DEL_IDX;
      else op = OP_DEL_VAL;
      w = $urandom_range(99, 0);
      if (w < 8) idx = $urandom_range(2047, 0);
      else if (w < 15) idx = (op == OP_INSERT) ? n + 1 : n;
      else if (op == OP_INSERT) idx = $urandom_range(n, 0);
      else idx = (n > 0) ? $urandom_range(n - 1, 0) : 0;
      if (op == OP_DEL_VAL && n > 0 && $urandom_range(9, 0) < 7)
        v = plan_vals[$urandom_range(n - 1, 0)];
      else
        v = pick_value();
      plan_item(op, idx, v, draw_gap(i), (i % 150 == 149));
    end

    i = 0;
    while (plan_vals.size() < DEPTH) begin
      v = ($urandom_range(7, 0) == 0) ? pick_value() : $urandom;
      plan_item(OP_INSERT, plan_vals.size(), v, draw_gap(i), (i == 0));
      i++;
    end
    plan_item(OP_INSERT, DEPTH, $urandom, draw_gap(1), 1'b0);
    plan_item(OP_INSERT, 0, $urandom, draw_gap(1), 1'b0);
    plan_item(OP_INSERT, DEPTH + 1, $urandom, draw_gap(1), 1'b0);
    plan_item(OP_READ, DEPTH - 1, 32'd0, draw_gap(1), 1'b0);
    plan_item(OP_READ, DEPTH, 32'd0, draw_gap(1), 1'b0);
    plan_item(OP_DEL_VAL, 0, plan_vals[DEPTH - 1], draw_gap(1), 1'b0);
    plan_item(OP_DEL_VAL, 0, $urandom, draw_gap(1), 1'b0);
    plan_item(OP_INSERT, 0, 32'h8000_0000, draw_gap(1), 1'b0);
    plan_item(OP_DEL_IDX, 0, 32'd0, draw_gap(1), 1'b0);
    plan_item(OP_DEL_IDX, DEPTH, 32'd0, draw_gap(1), 1'b0);
    for (i = 0; i < 10; i++) begin
      n = plan_vals.size();
      case ($urandom_range(3, 0))
        0: plan_item(OP_INSERT, $urandom_range(n, 0), $urandom, draw_gap(50), 1'b0);
        1: plan_item(OP_READ, $urandom_range(n - 1, 0), 32'd0, draw_gap(50), 1'b0);
        2: plan_item(OP_DEL_IDX, $urandom_range(n - 1, 0), 32'd0, draw_gap(50), 1'b0);
        default: plan_item(OP_DEL_VAL, $urandom_range(2047, 0),
                           plan_vals[$urandom_range(n - 1, 0)], draw_gap(50), 1'b0);
      endcase
    end

    cycle_limit = 4 * budget + 4 * HOLD_CYCLES + 1000;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    while (pending_q.size() != 0 || req_valid || expected_rsp_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Ran %0d requests (insert %0d, read %0d, delete at index %0d, delete by value %0d),",
             accepted, op_seen[0], op_seen[1], op_seen[2], op_seen[3]);
    $display("peak length %0d; statuses ok %0d, bad index %0d, full %0d, empty %0d, none %0d.",
             peak_len, status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4]);
    if (errors == 0 && expected_rsp_q.size() == 0) begin
      $display("array_list_insert_delete test passed");
    end else begin
      $display("array_list_insert_delete test failed");
    end
    $finish;
  end

endmodule
